FILE: rtl/core/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Shared widths, codes and controller/datapath interface types of the
// sorted region table.
// ----------------------------------------------------------------------------
package srt_pkg;

   localparam int MAX_REGIONS_DEF = 16;
   localparam int PAGE_SHIFT_DEF  = 12;
   localparam int MAX_RESULTS     = 16;
   localparam int ADDR_W          = 48;
   localparam int PAGE_W          = 36;
   localparam int FLAG_W          = 8;
   localparam int OBJ_W           = 16;
   localparam int OP_W            = 3;
   localparam int STATUS_W        = 2;
   localparam int NRES_W          = $clog2(MAX_RESULTS + 1);

   localparam logic [PAGE_W-1:0] TOP_PAGE_RESET = 36'h8_0000_0000;

   localparam logic [OP_W-1:0] OP_FIND       = 3'd0;
   localparam logic [OP_W-1:0] OP_FIND_EXACT = 3'd1;
   localparam logic [OP_W-1:0] OP_FIND_HOLE  = 3'd2;
   localparam logic [OP_W-1:0] OP_INSERT     = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0] offset;
      logic [OBJ_W-1:0]  obj;
      logic [FLAG_W-1:0] flags;
      logic [ADDR_W-1:0] stop;
      logic [ADDR_W-1:0] start;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_EV, S_HOLE_END,
      S_E_ENTRY, S_E_MISS, S_E_HOLE, S_E_FULL, S_E_INS,
      S_POS_RD, S_POS_EV, S_SH_START, S_SH_CHK, S_SH_WR, S_NEW_WR,
      S_RM_RD, S_RM_EV, S_RM_CALC, S_DR_CHK, S_DR_WR,
      S_RM_LEFT, S_RM_RIGHT, S_RM_PIECE, S_RM_END
   } state_type;

   typedef enum logic [1:0] {RD_I, RD_JM1, RD_JP1} rd_sel_type;
   typedef enum logic [0:0] {WR_SHIFT, WR_NEW} wr_sel_type;
   typedef enum logic [1:0] {NEW_REQ, NEW_LEFT, NEW_RIGHT} new_sel_type;
   typedef enum logic [2:0] {
      OUT_ENTRY, OUT_MISS, OUT_HOLE, OUT_FULL, OUT_INS, OUT_PEND_MID, OUT_PEND_LAST
   } out_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_sel_type  wr_sel;
      logic        i_clr;
      logic        i_inc;
      logic        j_from_count;
      logic        j_from_i;
      logic        j_dec;
      logic        j_inc;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        scan_upd;
      logic        cap_entry;
      logic        calc;
      logic        new_load;
      new_sel_type new_sel;
      logic        pend_load;
      logic        out_load;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            i_lt_count;
      logic            full;
      logic            j_gt_i;
      logic            jp1_lt_count;
      logic            hit;
      logic            stop_find;
      logic            hole_fit;
      logic            top_fit;
      logic            pos_stop;
      logic            overlap;
      logic            has_left;
      logic            has_right;
      logic            pend_valid;
      logic            n_lt_max;
      logic            out_free;
   } stat_type;

endpackage

FILE: rtl/core/srt_ram.sv
// ----------------------------------------------------------------------------
// srt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module srt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/srt_ctrl.sv
// ----------------------------------------------------------------------------
// srt_ctrl
// Sequencer for scans, sorted inserts, entry drops and range removal.
// ----------------------------------------------------------------------------
module srt_ctrl
   import srt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type   state_ff, state_in;
   new_sel_type kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= NEW_REQ;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (req_tvalid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            unique case (stat.op) inside
               OP_FIND, OP_FIND_EXACT, OP_FIND_HOLE: state_in = S_SCAN_RD;
               OP_INSERT: state_in = stat.full ? S_E_FULL : S_POS_RD;
               OP_REMOVE: state_in = S_RM_RD;
               default:   state_in = S_E_MISS;
            endcase
         end
         S_SCAN_RD: begin
            if (stat.i_lt_count) state_in = S_SCAN_EV;
            else if (stat.op == OP_FIND_HOLE) state_in = S_HOLE_END;
            else state_in = S_E_MISS;
         end
         S_SCAN_EV: begin
            if (stat.op == OP_FIND_HOLE) begin
               state_in = stat.hole_fit ? S_E_HOLE : S_SCAN_RD;
            end else if (stat.hit) begin
               state_in = S_E_ENTRY;
            end else begin
               state_in = stat.stop_find ? S_E_MISS : S_SCAN_RD;
            end
         end
         S_HOLE_END: state_in = stat.top_fit ? S_E_HOLE : S_E_MISS;
         S_E_ENTRY, S_E_MISS, S_E_HOLE, S_E_FULL, S_E_INS: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         S_POS_RD:   state_in = stat.i_lt_count ? S_POS_EV : S_SH_START;
         S_POS_EV:   state_in = stat.pos_stop ? S_SH_START : S_POS_RD;
         S_SH_START: state_in = S_SH_CHK;
         S_SH_CHK:   state_in = stat.j_gt_i ? S_SH_WR : S_NEW_WR;
         S_SH_WR:    state_in = S_SH_CHK;
         S_NEW_WR: begin
            unique case (kind_ff)
               NEW_REQ:  state_in = S_E_INS;
               NEW_LEFT: state_in = S_RM_RIGHT;
               default:  state_in = S_RM_PIECE;
            endcase
         end
         S_RM_RD:    state_in = stat.i_lt_count ? S_RM_EV : S_RM_END;
         S_RM_EV:    state_in = stat.overlap ? S_RM_CALC : S_RM_RD;
         S_RM_CALC:  state_in = S_DR_CHK;
         S_DR_CHK:   state_in = stat.jp1_lt_count ? S_DR_WR : S_RM_LEFT;
         S_DR_WR:    state_in = S_DR_CHK;
         S_RM_LEFT:  state_in = (stat.has_left && !stat.full) ? S_POS_RD : S_RM_RIGHT;
         S_RM_RIGHT: state_in = (stat.has_right && !stat.full) ? S_POS_RD : S_RM_PIECE;
         S_RM_PIECE: begin
            if (!stat.n_lt_max || !stat.pend_valid || stat.out_free) state_in = S_RM_RD;
         end
         S_RM_END:   if (stat.out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      kind_in    = kind_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         S_DISPATCH: begin
            if (stat.op == OP_INSERT && !stat.full) begin
               cmd.new_load = 1'b1;
               cmd.new_sel  = NEW_REQ;
               cmd.i_clr    = 1'b1;
               kind_in      = NEW_REQ;
            end
         end
         S_SCAN_RD, S_POS_RD, S_RM_RD: begin
            cmd.rd_en  = stat.i_lt_count;
            cmd.rd_sel = RD_I;
         end
         S_SCAN_EV: begin
            if (stat.op == OP_FIND_HOLE) begin
               if (!stat.hole_fit) begin
                  cmd.scan_upd = 1'b1;
                  cmd.i_inc    = 1'b1;
               end
            end else if (!stat.hit && !stat.stop_find) begin
               cmd.i_inc = 1'b1;
            end
         end
         S_E_ENTRY: begin
            cmd.out_load = stat.out_free;
            cmd.out_sel  = OUT_ENTRY;
         end
         S_E_MISS: begin
            cmd.out_load = stat.out_free;
            cmd.out_sel  = OUT_MISS;
         end
         S_E_HOLE: begin
            cmd.out_load = stat.out_free;
            cmd.out_sel  = OUT_HOLE;
         end
         S_E_FULL: begin
            cmd.out_load = stat.out_free;
            cmd.out_sel  = OUT_FULL;
         end
         S_E_INS: begin
            cmd.out_load = stat.out_free;
            cmd.out_sel  = OUT_INS;
         end
         S_POS_EV:   cmd.i_inc = !stat.pos_stop;
         S_SH_START: cmd.j_from_count = 1'b1;
         S_SH_CHK: begin
            cmd.rd_en  = stat.j_gt_i;
            cmd.rd_sel = RD_JM1;
         end
         S_SH_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_SHIFT;
            cmd.j_dec  = 1'b1;
         end
         S_NEW_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_NEW;
            cmd.cnt_inc = 1'b1;
         end
         S_RM_EV: begin
            cmd.cap_entry = stat.overlap;
            cmd.i_inc     = !stat.overlap;
         end
         S_RM_CALC: begin
            cmd.calc     = 1'b1;
            cmd.j_from_i = 1'b1;
         end
         S_DR_CHK: begin
            cmd.rd_en   = stat.jp1_lt_count;
            cmd.rd_sel  = RD_JP1;
            cmd.cnt_dec = !stat.jp1_lt_count;
         end
         S_DR_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_SHIFT;
            cmd.j_inc  = 1'b1;
         end
         S_RM_LEFT: begin
            if (stat.has_left && !stat.full) begin
               cmd.new_load = 1'b1;
               cmd.new_sel  = NEW_LEFT;
               cmd.i_clr    = 1'b1;
               kind_in      = NEW_LEFT;
            end
         end
         S_RM_RIGHT: begin
            if (stat.has_right && !stat.full) begin
               cmd.new_load = 1'b1;
               cmd.new_sel  = NEW_RIGHT;
               cmd.i_clr    = 1'b1;
               kind_in      = NEW_RIGHT;
            end
         end
         S_RM_PIECE: begin
            cmd.out_sel = OUT_PEND_MID;
            if (!stat.n_lt_max) begin
               cmd.i_clr = 1'b1;
            end else if (!stat.pend_valid) begin
               cmd.pend_load = 1'b1;
               cmd.i_clr     = 1'b1;
            end else if (stat.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.pend_load = 1'b1;
               cmd.i_clr     = 1'b1;
            end
         end
         S_RM_END: begin
            cmd.out_load = stat.out_free;
            cmd.out_sel  = stat.pend_valid ? OUT_PEND_LAST : OUT_MISS;
         end
         default: cmd = '0;
      endcase
   end

endmodule

FILE: rtl/core/srt_dp.sv
// ----------------------------------------------------------------------------
// srt_dp
// Region table datapath: entry RAM, indexes, compares, remnant math and
// the result register.
// ----------------------------------------------------------------------------
module srt_dp
   import srt_pkg::*;
#(
   parameter int MAX_REGIONS = MAX_REGIONS_DEF,
   parameter int PAGE_SHIFT  = PAGE_SHIFT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [OP_W-1:0]     req_op,
   input  logic [239:0]        req_data,
   input  logic [PAGE_W-1:0]   top_page,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [207:0]        rsp_tdata,
   output logic [STATUS_W-1:0] rsp_tuser,
   output logic                rsp_tlast
);

   localparam int CW   = $clog2(MAX_REGIONS + 1);
   localparam int IW   = $clog2(MAX_REGIONS);
   localparam int RB_W = PAGE_W + 1 + PAGE_SHIFT;

   logic [OP_W-1:0]   op_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [PAGE_W-1:0] page_ff, cnt_ff, scan_ff;
   entry_type         req_ent_ff, nw_ff, vic_ff, pend_ff, rd_data;
   logic [CW-1:0]     count_ff, i_ff, j_ff;
   logic [ADDR_W-1:0] rs_ff, re_ff;
   logic              pend_valid_ff;
   logic [NRES_W-1:0] n_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] out_status_ff;
   entry_type           out_ent_ff;
   logic [PAGE_W-1:0]   out_hole_ff;
   logic                out_last_ff;

   logic [CW-1:0]     jm1, jp1;
   logic [IW-1:0]     rd_addr, wr_addr;
   entry_type         wr_data, new_ent;
   logic [RB_W-1:0]   ra_w, rb_w;
   logic [PAGE_W-1:0] sp, ep;
   entry_type         piece;

   srt_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_REGIONS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign jm1 = j_ff - 1'b1;
   assign jp1 = j_ff + 1'b1;

   always_comb begin
      case (cmd.rd_sel)
         RD_JM1:  rd_addr = jm1[IW-1:0];
         RD_JP1:  rd_addr = jp1[IW-1:0];
         default: rd_addr = i_ff[IW-1:0];
      endcase
   end

   assign wr_addr = (cmd.wr_sel == WR_NEW) ? i_ff[IW-1:0] : j_ff[IW-1:0];
   assign wr_data = (cmd.wr_sel == WR_NEW) ? nw_ff : rd_data;

   assign ra_w = {1'b0, page_ff, {PAGE_SHIFT{1'b0}}};
   assign rb_w = {({1'b0, page_ff} + {1'b0, cnt_ff}), {PAGE_SHIFT{1'b0}}};
   assign sp   = PAGE_W'(rd_data.start >> PAGE_SHIFT);
   assign ep   = PAGE_W'(rd_data.stop >> PAGE_SHIFT);

   always_comb begin
      new_ent = req_ent_ff;
      case (cmd.new_sel)
         NEW_LEFT: begin
            new_ent      = vic_ff;
            new_ent.stop = rs_ff;
         end
         NEW_RIGHT: begin
            new_ent        = vic_ff;
            new_ent.start  = re_ff;
            new_ent.offset = vic_ff.offset + (re_ff - vic_ff.start);
         end
         default: new_ent = req_ent_ff;
      endcase
   end

   always_comb begin
      piece        = vic_ff;
      piece.start  = rs_ff;
      piece.stop   = re_ff;
      piece.offset = vic_ff.offset + (rs_ff - vic_ff.start);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         n_ff          <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
      end else begin
         if (cmd.load_req) begin
            pend_valid_ff <= 1'b0;
            n_ff          <= '0;
         end else if (cmd.pend_load) begin
            pend_valid_ff <= 1'b1;
            n_ff          <= n_ff + 1'b1;
         end
         if (cmd.cnt_inc) count_ff <= count_ff + 1'b1;
         else if (cmd.cnt_dec) count_ff <= count_ff - 1'b1;
         if (cmd.load_req || cmd.i_clr) i_ff <= '0;
         else if (cmd.i_inc) i_ff <= i_ff + 1'b1;
         if (cmd.j_from_count) j_ff <= count_ff;
         else if (cmd.j_from_i) j_ff <= i_ff;
         else if (cmd.j_dec) j_ff <= jm1;
         else if (cmd.j_inc) j_ff <= jp1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff             <= req_op;
         addr_ff           <= req_data[47:0];
         req_ent_ff.start  <= req_data[47:0];
         req_ent_ff.stop   <= req_data[95:48];
         page_ff           <= req_data[131:96];
         cnt_ff            <= req_data[167:132];
         req_ent_ff.flags  <= req_data[175:168];
         req_ent_ff.obj    <= req_data[191:176];
         req_ent_ff.offset <= req_data[239:192];
         scan_ff           <= req_data[131:96];
      end else if (cmd.scan_upd && ep > scan_ff) begin
         scan_ff <= ep;
      end
      if (cmd.new_load) nw_ff <= new_ent;
      if (cmd.cap_entry) vic_ff <= rd_data;
      if (cmd.calc) begin
         rs_ff <= ({{(RB_W-ADDR_W){1'b0}}, vic_ff.start} > ra_w) ? vic_ff.start
                                                                : ra_w[ADDR_W-1:0];
         re_ff <= ({{(RB_W-ADDR_W){1'b0}}, vic_ff.stop} < rb_w) ? vic_ff.stop
                                                               : rb_w[ADDR_W-1:0];
      end
      if (cmd.pend_load) pend_ff <= piece;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_status_ff <= STATUS_OK;
         out_ent_ff    <= '0;
         out_hole_ff   <= '0;
         out_last_ff   <= 1'b1;
         case (cmd.out_sel)
            OUT_ENTRY:     out_ent_ff <= rd_data;
            OUT_MISS:      out_status_ff <= STATUS_MISS;
            OUT_HOLE:      out_hole_ff <= scan_ff;
            OUT_FULL:      out_status_ff <= STATUS_FULL;
            OUT_INS:       out_ent_ff <= req_ent_ff;
            OUT_PEND_MID: begin
               out_ent_ff  <= pend_ff;
               out_last_ff <= 1'b0;
            end
            OUT_PEND_LAST: out_ent_ff <= pend_ff;
            default:       out_status_ff <= STATUS_MISS;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {4'b0, out_hole_ff, out_ent_ff.offset, out_ent_ff.obj,
                        out_ent_ff.flags, out_ent_ff.stop, out_ent_ff.start};

   always_comb begin
      stat              = '0;
      stat.op           = op_ff;
      stat.i_lt_count   = i_ff < count_ff;
      stat.full         = count_ff == CW'(MAX_REGIONS);
      stat.j_gt_i       = j_ff > i_ff;
      stat.jp1_lt_count = jp1 < count_ff;
      stat.hit          = (op_ff == OP_FIND)
                          ? (addr_ff >= rd_data.start && addr_ff < rd_data.stop)
                          : (addr_ff == rd_data.start);
      stat.stop_find    = addr_ff < rd_data.start;
      stat.hole_fit     = (sp > scan_ff) && ((sp - scan_ff) >= cnt_ff);
      stat.top_fit      = (top_page > scan_ff) && ((top_page - scan_ff) >= cnt_ff);
      stat.pos_stop     = (i_ff == '0) ? (nw_ff.start < rd_data.start)
                                       : !(rd_data.start < nw_ff.start);
      stat.overlap      = ({{(RB_W-ADDR_W){1'b0}}, rd_data.stop} > ra_w) &&
                          ({{(RB_W-ADDR_W){1'b0}}, rd_data.start} < rb_w);
      stat.has_left     = vic_ff.start < rs_ff;
      stat.has_right    = re_ff < vic_ff.stop;
      stat.pend_valid   = pend_valid_ff;
      stat.n_lt_max     = n_ff < NRES_W'(MAX_RESULTS);
      stat.out_free     = !rsp_valid_ff || rsp_tready;
   end

endmodule

FILE: rtl/core/sorted_region_table.sv
// ----------------------------------------------------------------------------
// sorted_region_table
// Address region table kept sorted by start, with lookup, hole search,
// sorted insert and page-range removal.
// ----------------------------------------------------------------------------
// One request is processed at a time. All entries live in a single RAM with
// a registered read, so every table walk or entry shift first reads an
// entry and then evaluates or writes it. A removal scans for a region that
// overlaps the page range, drops it by shifting the later entries down,
// re-inserts its left and right remnants while the table has room, and
// scans again from the first entry. Results wait in an output register;
// removed pieces stream out as they are found, tlast on the final.
// ----------------------------------------------------------------------------
module sorted_region_table
   import srt_pkg::*;
#(
   parameter int MAX_REGIONS = MAX_REGIONS_DEF,
   parameter int PAGE_SHIFT  = PAGE_SHIFT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // address, end_address, page, page_count, region_flags_in, object_id,
   // object_offset
   input  logic [239:0]        req_tdata,
   // op
   input  logic [OP_W-1:0]     req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // found_start, found_end, found_flags, found_object, found_offset,
   // hole_page, zero fill
   output logic [207:0]        rsp_tdata,
   // status
   output logic [STATUS_W-1:0] rsp_tuser,
   output logic                rsp_tlast,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [63:0]         csr_pwdata,
   output logic [63:0]         csr_prdata,
   output logic                csr_pready
);

   logic [PAGE_W-1:0] top_page_ff;
   cmd_type           cmd;
   stat_type          stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_page_ff <= TOP_PAGE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         top_page_ff <= csr_pwdata[PAGE_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 3'd0) ? {{(64-PAGE_W){1'b0}}, top_page_ff} : 64'd0;

   srt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   srt_dp #(
      .MAX_REGIONS (MAX_REGIONS),
      .PAGE_SHIFT  (PAGE_SHIFT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_op     (req_tuser),
      .req_data   (req_tdata),
      .top_page   (top_page_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
